@@ hw/rtl/ecal_pkg.sv @@
// ----------------------------------------------------------------------------
// ecal_pkg
// Shared types and constants of the event calendar: operation codes,
// sequencer states and the result item layout.
// ----------------------------------------------------------------------------
package ecal_pkg;

  localparam int TIME_W    = 32;
  localparam int IDX_W     = 3;
  localparam int RES_IDX_W = 4;

  typedef enum logic [2:0] {
    FN_SET_SOURCE  = 3'd0,
    FN_SET_DEVICE  = 3'd1,
    FN_FREE_DEVICE = 3'd2,
    FN_NEXT_SOURCE = 3'd3,
    FN_NEXT_DEVICE = 3'd4,
    FN_FREE_SEARCH = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FSRCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 found;
    logic [RES_IDX_W-1:0] result_index;
    logic [TIME_W-1:0]    result_time;
  } result_t;

endpackage

@@ hw/rtl/ecal_req_if.sv @@
// ----------------------------------------------------------------------------
// ecal_req_if
// Request channel of the event calendar: valid/ready plus one item.
// ----------------------------------------------------------------------------
interface ecal_req_if import ecal_pkg::*;;
  logic              valid;
  logic              ready;
  logic [2:0]        func;
  logic [IDX_W-1:0]  entry_index;
  logic [TIME_W-1:0] time_value;

  modport source (output valid, func, entry_index, time_value, input ready);
  modport sink   (input valid, func, entry_index, time_value, output ready);
endinterface

@@ hw/rtl/ecal_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ecal_rsp_if
// Result channel of the event calendar: valid/ready plus one item.
// ----------------------------------------------------------------------------
interface ecal_rsp_if import ecal_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [RES_IDX_W-1:0] result_index;
  logic [TIME_W-1:0]    result_time;

  modport source (output valid, found, result_index, result_time, input ready);
  modport sink   (input valid, found, result_index, result_time, output ready);
endinterface

@@ hw/rtl/ecal_ram.sv @@
// ----------------------------------------------------------------------------
// ecal_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ecal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/event_calendar_next_and_free_search_core.sv @@
// ----------------------------------------------------------------------------
// event_calendar_next_and_free_search_core
// Event calendar: source generation times, device end-of-service times and
// device free marks, with next-event and round-robin free-device queries.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item (func, entry_index, time_value); rsp returns exactly
//   one result item (found, result_index, result_time) for every request.
//   A request is taken only while the sequencer is idle, one at a time.
//   Writes (set source, set device, mark free, unused codes) go straight to
//   the done state, which loads the result register. Next source / next
//   device read the time RAM one entry a cycle through a single 32-bit
//   comparator, passing through the scan, drain and done states before the
//   result is loaded. Free search checks one free mark a cycle, up to
//   NUM_DEVICES marks, then goes to the done state. The sequencer returns
//   to idle at the same edge that loads the result register.
//   The result sits in an output register; a new request is accepted while
//   it waits, and the sequencer holds in its final state until rsp.ready
//   frees the register.
//   Reset clears all source times to zero (via per-entry valid bits) and marks
//   every device free; no clearing pass is needed.
// ----------------------------------------------------------------------------
module event_calendar_next_and_free_search_core import ecal_pkg::*; #(
  parameter int NUM_SOURCES = 8,
  parameter int NUM_DEVICES = 8
) (
  input logic       clk,
  input logic       rst,
  ecal_req_if.sink  req,
  ecal_rsp_if.source rsp
);

  localparam int SAW  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int DAW  = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam int MAXN = (NUM_SOURCES > NUM_DEVICES) ? NUM_SOURCES : NUM_DEVICES;
  localparam int SW   = $clog2(MAXN + 1);

  state_t            state, state_next;
  func_t             fn;
  logic              acc;
  logic              src_in_range, dev_in_range;
  logic              src_we, dev_we;
  logic [SAW-1:0]    src_waddr;
  logic [DAW-1:0]    dev_waddr;
  logic [TIME_W-1:0] src_rdata, dev_rdata;
  logic [SW-1:0]     sc, sc_last;
  logic              rd_vld;
  logic [SW-1:0]     rd_idx;
  logic [TIME_W-1:0] cand_time;
  logic              take;
  logic              any;
  logic [SW-1:0]     best_idx;
  logic [TIME_W-1:0] best_time;
  logic [NUM_SOURCES-1:0] src_vld;
  logic [NUM_DEVICES-1:0] free;
  logic [DAW-1:0]    fpos, fstart;
  logic [SW-1:0]     fcnt;
  logic              fhit;
  logic              res_vld, res_load;
  result_t           res, res_next;

  assign acc          = req.valid && req.ready;
  assign src_in_range = int'(req.entry_index) < NUM_SOURCES;
  assign dev_in_range = int'(req.entry_index) < NUM_DEVICES;
  assign src_waddr    = SAW'(req.entry_index);
  assign dev_waddr    = DAW'(req.entry_index);
  assign fstart       = dev_in_range ? dev_waddr : '0;
  assign src_we = acc && (req.func == FN_SET_SOURCE) && src_in_range;
  assign dev_we = acc && (req.func == FN_SET_DEVICE) && dev_in_range;
  assign sc_last = (fn == FN_NEXT_SOURCE) ? SW'(NUM_SOURCES - 1) : SW'(NUM_DEVICES - 1);

  ecal_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SOURCES)) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (src_waddr),
    .wdata (req.time_value),
    .raddr (sc[SAW-1:0]),
    .rdata (src_rdata)
  );

  ecal_ram #(.WIDTH(TIME_W), .DEPTH(NUM_DEVICES)) u_dev_ram (
    .clk   (clk),
    .we    (dev_we),
    .waddr (dev_waddr),
    .wdata (req.time_value),
    .raddr (sc[DAW-1:0]),
    .rdata (dev_rdata)
  );

  // A never-written source entry reads as zero; a device time is only used
  // while busy, and busy implies written.
  always_comb begin
    if (fn == FN_NEXT_SOURCE) begin
      cand_time = src_vld[rd_idx[SAW-1:0]] ? src_rdata : '0;
      take      = !any || (cand_time < best_time);
    end else begin
      cand_time = dev_rdata;
      take      = !free[rd_idx[DAW-1:0]] && (!any || (cand_time < best_time));
    end
  end

  always_comb begin
    unique case (fn)
      FN_NEXT_SOURCE, FN_NEXT_DEVICE: begin
        res_next.found        = any;
        res_next.result_index = RES_IDX_W'(best_idx);
        res_next.result_time  = best_time;
      end
      FN_FREE_SEARCH: begin
        res_next.found        = fhit;
        res_next.result_index = fhit ? RES_IDX_W'(fpos) : RES_IDX_W'(NUM_DEVICES);
        res_next.result_time  = '0;
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    res_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          case (req.func)
            FN_NEXT_SOURCE, FN_NEXT_DEVICE: state_next = ST_SCAN;
            FN_FREE_SEARCH:                 state_next = ST_FSRCH;
            default:                        state_next = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (sc == sc_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_FSRCH: begin
        if (free[fpos] || (fcnt == SW'(NUM_DEVICES - 1))) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!res_vld || rsp.ready) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Writes land at accept time and requests are taken only while idle, so scan
  // reads never overlap a write to the same entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      src_vld <= '0;
      free    <= '1;
      res_vld <= 1'b0;
      rd_vld  <= 1'b0;
    end else begin
      if (src_we) begin
        src_vld[src_waddr] <= 1'b1;
      end
      if (dev_we) begin
        free[dev_waddr] <= 1'b0;
      end
      if (acc && (req.func == FN_FREE_DEVICE) && dev_in_range) begin
        free[dev_waddr] <= 1'b1;
      end
      rd_vld <= (state == ST_SCAN);
      if (res_load) begin
        res_vld <= 1'b1;
      end else if (rsp.ready) begin
        res_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      fn        <= func_t'(req.func);
      sc        <= '0;
      any       <= 1'b0;
      best_idx  <= '0;
      best_time <= '0;
      fpos      <= fstart;
      fcnt      <= '0;
      fhit      <= 1'b0;
    end else begin
      if (state == ST_SCAN) begin
        sc <= sc + SW'(1);
      end
      if (rd_vld && take) begin
        any       <= 1'b1;
        best_idx  <= rd_idx;
        best_time <= cand_time;
      end
      if (state == ST_FSRCH) begin
        if (free[fpos]) begin
          fhit <= 1'b1;
        end else if (fcnt != SW'(NUM_DEVICES - 1)) begin
          // advance round-robin, wrap at the last device
          fpos <= (int'(fpos) == NUM_DEVICES - 1) ? '0 : fpos + DAW'(1);
          fcnt <= fcnt + SW'(1);
        end
      end
    end
    rd_idx <= sc;
    if (res_load) begin
      res <= res_next;
    end
  end

  assign rsp.valid        = res_vld;
  assign rsp.found        = res.found;
  assign rsp.result_index = res.result_index;
  assign rsp.result_time  = res.result_time;

endmodule

@@ bench/event_calendar_next_and_free_search_core_tb.sv @@
// ----------------------------------------------------------------------------
// event_calendar_next_and_free_search_core_tb
// Self-checking bench for the event calendar. It sends table writes,
// next-event queries and free-device searches over the request channel.
// It keeps its own copy of the source times, device times and free marks.
// It predicts every result item and compares each one, field by field, in
// order. Both sides insert random gaps, and the result side holds off once for
// a long stretch so that the core fills up and stalls its input.
// ----------------------------------------------------------------------------
module event_calendar_next_and_free_search_core_tb import ecal_pkg::*;;

  localparam int NSRC = 8;
  localparam int NDEV = 8;
  localparam int RANDOM_ITEMS = 1850;
  localparam logic [2:0] FN_UNUSED_LO = 3'd6;
  localparam logic [2:0] FN_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [2:0]        func;
    logic [IDX_W-1:0]  entry;
    logic [TIME_W-1:0] tval;
  } cal_req_t;

  logic clk;
  logic rst;

  ecal_req_if req_ch ();
  ecal_rsp_if rsp_ch ();

  event_calendar_next_and_free_search_core #(
    .NUM_SOURCES(NSRC),
    .NUM_DEVICES(NDEV)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Calendar state as the bench sees it
  logic [TIME_W-1:0] src_time [NSRC];
  logic [TIME_W-1:0] dev_time [NDEV];
  bit                dev_free [NDEV];

  cal_req_t pending_reqs [$];
  result_t  expected_results [$];

  int  err_count   = 0;
  int  items_taken = 0;
  bit  req_taken   = 1'b0;
  bit  no_idle     = 1'b0;
  bit  hold_off    = 1'b0;
  int  req_gap     = 0;
  int  rsp_stall   = 0;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.func        = '0;
    req_ch.entry_index = '0;
    req_ch.time_value  = '0;
    rsp_ch.ready       = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
  end

  // Apply one item to the bench's calendar copy and return its answer
  function automatic result_t calendar_answer(logic [2:0] fn, logic [IDX_W-1:0] idx,
                                              logic [TIME_W-1:0] tv);
    result_t ans;
    int      best;
    bit      any;
    int      start;
    int      d;
    ans  = '0;
    best = 0;
    any  = 1'b0;
    case (fn)
      FN_SET_SOURCE: if (idx < NSRC) src_time[idx] = tv;
      FN_SET_DEVICE: begin
        if (idx < NDEV) begin
          dev_time[idx] = tv;
          dev_free[idx] = 1'b0;
        end
      end
      FN_FREE_DEVICE: if (idx < NDEV) dev_free[idx] = 1'b1;
      FN_NEXT_SOURCE: begin
        for (int i = 1; i < NSRC; i++)
          if (src_time[i] < src_time[best]) best = i;
        ans.found        = 1'b1;
        ans.result_index = RES_IDX_W'(best);
        ans.result_time  = src_time[best];
      end
      FN_NEXT_DEVICE: begin
        for (int i = 0; i < NDEV; i++) begin
          if (!dev_free[i] && (!any || dev_time[i] < dev_time[best])) begin
            best = i;
            any  = 1'b1;
          end
        end
        if (any) begin
          ans.found        = 1'b1;
          ans.result_index = RES_IDX_W'(best);
          ans.result_time  = dev_time[best];
        end
      end
      FN_FREE_SEARCH: begin
        start = (idx < NDEV) ? int'(idx) : 0;
        ans.result_index = RES_IDX_W'(NDEV);
        for (int k = 0; k < NDEV; k++) begin
          d = (start + k) % NDEV;
          if (!ans.found && dev_free[d]) begin
            ans.found        = 1'b1;
            ans.result_index = RES_IDX_W'(d);
          end
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return '0;
      1:       return '1;
      2, 3, 4: return TIME_W'($urandom_range(0, 7));
      5:       return 32'hFFFF_FFF0 + TIME_W'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // Mostly short gaps, a few long ones, none while no_idle is set
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_item(logic [2:0] fn, int idx, logic [TIME_W-1:0] tv);
    cal_req_t it;
    it.func  = fn;
    it.entry = IDX_W'(idx);
    it.tval  = tv;
    pending_reqs.push_back(it);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    $display("ERROR @%0t %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // Request driver: hold an item until taken, then gap or present the next one
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !req_taken) begin
      req_ch.valid <= 1'b1;
    end else if (req_gap > 0) begin
      req_ch.valid <= 1'b0;
      req_gap = req_gap - 1;
    end else if (pending_reqs.size() != 0) begin
      cal_req_t it;
      it = pending_reqs.pop_front();
      req_ch.func        <= it.func;
      req_ch.entry_index <= it.entry;
      req_ch.time_value  <= it.tval;
      req_ch.valid       <= 1'b1;
      req_gap = pick_gap();
    end else begin
      req_ch.valid <= 1'b0;
    end
  end

  // Result side ready with random stalls and one long hold-off
  always @(negedge clk) begin
    if (rst || hold_off) begin
      rsp_ch.ready <= 1'b0;
    end else if (rsp_stall > 0) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall = rsp_stall - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      rsp_stall = pick_gap();
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_ch.valid && req_ch.ready;
      // Check the result before logging this edge's request
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result item",
                          32'({rsp_ch.found, rsp_ch.result_index}), 32'(0));
        end else begin
          want = expected_results.pop_front();
          if (rsp_ch.found !== want.found)
            report_mismatch("found", 32'(rsp_ch.found), 32'(want.found));
          if (rsp_ch.result_index !== want.result_index)
            report_mismatch("result_index", 32'(rsp_ch.result_index),
                            32'(want.result_index));
          if (rsp_ch.result_time !== want.result_time)
            report_mismatch("result_time", rsp_ch.result_time, want.result_time);
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        expected_results.push_back(calendar_answer(req_ch.func, req_ch.entry_index,
                                                   req_ch.time_value));
        items_taken++;
      end
    end
  end

  // Alternate between idling and back-to-back stretches
  initial begin
    forever begin
      repeat ($urandom_range(300, 1500)) @(posedge clk);
      no_idle = ~no_idle;
    end
  end

  // Starve the result side long enough for the request side to back up
  initial begin
    wait (items_taken >= 400);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #2000000;
    $display("event_calendar_next_and_free_search_core: mismatch");
    $finish;
  end

  initial begin : stimulus
    int sent;
    int kind;
    int n;
    for (int i = 0; i < NSRC; i++) src_time[i] = '0;
    for (int i = 0; i < NDEV; i++) begin
      dev_time[i] = '0;
      dev_free[i] = 1'b1;
    end

    // Directed: reset contents, ties, no free device, wrap-around, unused codes
    add_item(FN_NEXT_SOURCE, 0, '0);
    add_item(FN_NEXT_DEVICE, 0, '0);
    add_item(FN_FREE_SEARCH, 5, '0);
    add_item(FN_SET_SOURCE, 0, '1);
    add_item(FN_NEXT_SOURCE, 7, '1);
    for (int i = 0; i < NDEV; i++)
      add_item(FN_SET_DEVICE, i, (i == 4 || i == 6) ? 32'd5 : '1);
    add_item(FN_FREE_SEARCH, 3, '0);
    add_item(FN_NEXT_DEVICE, 0, '0);
    add_item(FN_FREE_DEVICE, 4, '1);
    add_item(FN_NEXT_DEVICE, 7, '0);
    add_item(FN_FREE_DEVICE, 2, '0);
    add_item(FN_FREE_SEARCH, 5, '1);
    add_item(FN_UNUSED_LO, 7, '1);
    add_item(FN_UNUSED_HI, 7, '1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        // random mix of writes and queries
        n = $urandom_range(1, 8);
        for (int j = 0; j < n; j++)
          add_item(func_t'($urandom_range(FN_SET_SOURCE, FN_FREE_SEARCH)),
                   $urandom_range(0, 7), pick_time());
        sent += n;
      end else if (kind < 60) begin
        // all devices busy, then search and query
        for (int i = 0; i < NDEV; i++) add_item(FN_SET_DEVICE, i, pick_time());
        add_item(FN_FREE_SEARCH, $urandom_range(0, 7), $urandom);
        add_item(FN_NEXT_DEVICE, $urandom_range(0, 7), $urandom);
        sent += NDEV + 2;
      end else if (kind < 75) begin
        // free a random subset, possibly all, then query
        n = $urandom_range(0, 1) ? 8'hFF : 8'($urandom);
        for (int i = 0; i < NDEV; i++)
          if (n[i]) add_item(FN_FREE_DEVICE, i, $urandom);
        add_item(FN_NEXT_DEVICE, $urandom_range(0, 7), $urandom);
        add_item(FN_FREE_SEARCH, $urandom_range(0, 7), $urandom);
        sent += $countones(8'(n)) + 2;
      end else if (kind < 90) begin
        // sources with close times to force ties
        n = $urandom_range(1, 8);
        for (int j = 0; j < n; j++)
          add_item(FN_SET_SOURCE, $urandom_range(0, 7), TIME_W'($urandom_range(0, 3)));
        add_item(FN_NEXT_SOURCE, $urandom_range(0, 7), $urandom);
        sent += n + 1;
      end else if (kind < 95) begin
        // busy devices with equal times, then next device
        n = 0;
        for (int i = 0; i < NDEV; i++) begin
          if ($urandom_range(0, 1)) begin
            add_item(FN_SET_DEVICE, i, TIME_W'($urandom_range(0, 2)));
            n++;
          end
        end
        add_item(FN_NEXT_DEVICE, $urandom_range(0, 7), $urandom);
        sent += n + 1;
      end else begin
        // unused codes: no state change, zero answer
        add_item($urandom_range(0, 1) ? FN_UNUSED_HI : FN_UNUSED_LO,
                 $urandom_range(0, 7), $urandom);
        sent += 1;
      end
    end

    wait (!rst);
    while (pending_reqs.size() != 0 || req_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_count == 0)
      $display("event_calendar_next_and_free_search_core: match");
    else
      $display("event_calendar_next_and_free_search_core: mismatch");
    $finish;
  end

endmodule
